### src/tlrb_pkg.sv
// Shared types and constants for the terminated line receive buffer.
// No dependencies; imported by every module of the block.
package tlrb_pkg;

	// Result kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_LINE  = 2'd2;
	localparam logic [1:0] KIND_ECHO  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_TERMINATOR = 2'd0;
	localparam logic [1:0] CFG_PRINT_MIN  = 2'd1;
	localparam logic [1:0] CFG_ECHO_MODE  = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Input transaction
	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} tlrb_in_t;

	// Result transaction
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
		logic       end_overflow;
	} tlrb_out_t;

	// End-position queue status
	typedef struct packed {
		logic full;
		logic empty;
	} endq_stat_t;

endpackage

### src/tlrb_ring.sv
// Line byte ring: 8-bit synchronous memory with the write index.
// Depends on tlrb_pkg (nothing used beyond the common import style).
module tlrb_ring #(
	parameter int RING_DEPTH = 64,
	parameter int AW = $clog2(RING_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wr_idx,
	output logic [7:0]    rd_data
);
	import tlrb_pkg::*;

	logic [7:0]    mem [RING_DEPTH];
	logic [AW-1:0] wr_idx_q;
	logic [7:0]    rd_data_q;

	// write index, wraps at the ring depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
		end else if (wr_en) begin
			wr_idx_q <= (wr_idx_q == AW'(RING_DEPTH - 1)) ? '0 : wr_idx_q + AW'(1);
		end
	end

	// memory write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign wr_idx  = wr_idx_q;
	assign rd_data = rd_data_q;

endmodule

### src/tlrb_endq.sv
// End-position FIFO: synchronous memory of line end positions with head,
// tail and count. Depends on tlrb_pkg for the status struct.
module tlrb_endq #(
	parameter int END_DEPTH = 16,
	parameter int RAW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [RAW-1:0]       push_pos,
	input  logic                 pop,
	output logic [RAW-1:0]       pop_pos,
	output tlrb_pkg::endq_stat_t stat
);
	import tlrb_pkg::*;

	localparam int EAW = (END_DEPTH > 1) ? $clog2(END_DEPTH) : 1;
	localparam int CW  = $clog2(END_DEPTH + 1);

	logic [RAW-1:0] mem [END_DEPTH];
	logic [EAW-1:0] head_q;
	logic [EAW-1:0] tail_q;
	logic [CW-1:0]  count_q;
	logic [RAW-1:0] pop_pos_q;

	// pointers and fill count; push and pop never coincide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q  <= (tail_q == EAW'(END_DEPTH - 1)) ? '0 : tail_q + EAW'(1);
				count_q <= count_q + CW'(1);
			end
			if (pop) begin
				head_q  <= (head_q == EAW'(END_DEPTH - 1)) ? '0 : head_q + EAW'(1);
				count_q <= count_q - CW'(1);
			end
		end
	end

	// memory: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_pos;
		end
		if (pop) begin
			pop_pos_q <= mem[head_q];
		end
	end

	assign pop_pos    = pop_pos_q;
	assign stat.full  = (count_q == CW'(END_DEPTH));
	assign stat.empty = (count_q == '0);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("pop from empty end queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("push into full end queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q == $past(count_q) + CW'(1)) else $error("count not advanced");

endmodule

### src/terminated_line_receive_buffer_core.sv
// Top level of the terminated line receive buffer: configuration registers,
// read index and line sequencer. Depends on tlrb_pkg, tlrb_ring, tlrb_endq.
//
//  channel   handshake           payload              notes
//  input     start && !busy      item   (tlrb_in_t)   one transaction per accept
//  result    strobe              result (tlrb_out_t)  one cycle, cannot stall
//  config    cfg_we              cfg_index, cfg_data  write only, no wait
//
// A received byte is taken without raising busy; its echo or overflow notice
// shows in the cycle after. A line request with no line pending leaves busy
// low. A pending line holds busy while the end-position memory is read, then
// sends one line byte per cycle (an empty line ends after that read), paced by
// the ring's read port. Results lag the internal step by one register. Reset
// clears all indexes and counters at once; no clearing pass is needed.
module terminated_line_receive_buffer_core #(
	parameter int RING_DEPTH = 64,
	parameter int END_DEPTH  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  tlrb_pkg::tlrb_in_t                    item,
	output logic                                  strobe,
	output tlrb_pkg::tlrb_out_t                   result,
	input  logic                                  cfg_we,
	input  logic [tlrb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tlrb_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import tlrb_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_LINE = 2'd2;

	logic [1:0]    state_q;
	logic [7:0]    term_q;
	logic [7:0]    pmin_q;
	logic          echo_q;
	logic [AW-1:0] rd_idx_q;
	logic          strobe_q;
	tlrb_out_t     result_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] end_q;
	logic          last_s1;

	logic          accept;
	logic          rx_term;
	logic          rx_keep;
	logic          ovf;
	logic          ring_we;
	logic          push;
	logic          pop;
	logic [AW-1:0] wr_idx;
	logic [7:0]    rd_data;
	logic [AW-1:0] epos;
	endq_stat_t    eq_stat;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] ptr_next;
	logic          last_next;
	logic          res_vld;
	tlrb_out_t     res_d;
	logic [1:0]    state_d;

	// input decode
	assign accept  = start && !busy;
	assign rx_term = (item.rx_byte == term_q);
	assign rx_keep = !rx_term && (item.rx_byte >= pmin_q);
	assign ovf     = rx_term && eq_stat.full;
	assign ring_we = accept && !item.func && rx_keep;
	assign push    = accept && !item.func && rx_term && !eq_stat.full;
	assign pop     = accept && item.func && !eq_stat.empty;

	tlrb_ring #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ring_we),
		.wr_data (item.rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_idx  (wr_idx),
		.rd_data (rd_data)
	);

	tlrb_endq #(.END_DEPTH(END_DEPTH), .RAW(AW)) u_endq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pos (wr_idx),
		.pop      (pop),
		.pop_pos  (epos),
		.stat     (eq_stat)
	);

	// ring read address: line start after the pop, then the running pointer
	assign rd_addr   = (state_q == ST_POP) ? rd_idx_q : ptr_q;
	assign rd_en     = ((state_q == ST_POP) && (epos != rd_idx_q)) ||
	                   ((state_q == ST_LINE) && !last_s1);
	assign ptr_next  = (rd_addr == AW'(RING_DEPTH - 1)) ? '0 : rd_addr + AW'(1);
	assign last_next = (ptr_next == ((state_q == ST_POP) ? epos : end_q));

	// sequencer and result selection
	always_comb begin
		state_d = state_q;
		res_vld = 1'b0;
		res_d   = '{kind: KIND_NONE, out_byte: 8'd0, last: 1'b1, end_overflow: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (accept && !item.func) begin
					if (echo_q) begin
						res_vld = 1'b1;
						res_d   = '{kind: KIND_ECHO, out_byte: item.rx_byte, last: 1'b1,
						            end_overflow: ovf};
					end else if (ovf) begin
						res_vld            = 1'b1;
						res_d.end_overflow = 1'b1;
					end
				end else if (accept) begin
					if (eq_stat.empty) begin
						res_vld = 1'b1;
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_POP: begin
				if (epos == rd_idx_q) begin
					res_vld    = 1'b1;
					res_d.kind = KIND_EMPTY;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_LINE;
				end
			end
			ST_LINE: begin
				res_vld = 1'b1;
				res_d   = '{kind: KIND_LINE, out_byte: rd_data, last: last_s1,
				            end_overflow: 1'b0};
				if (last_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			rd_idx_q <= '0;
			term_q   <= 8'd10;
			pmin_q   <= 8'd32;
			echo_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= res_vld;
			if (state_q == ST_POP) begin
				rd_idx_q <= epos;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TERMINATOR: term_q <= cfg_data;
					CFG_PRINT_MIN:  pmin_q <= cfg_data;
					CFG_ECHO_MODE:  echo_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// payload and line pointer registers
	always_ff @(posedge clk) begin
		if (res_vld) begin
			result_q <= res_d;
		end
		if (state_q == ST_POP) begin
			end_q <= epos;
		end
		if (rd_en) begin
			ptr_q   <= ptr_next;
			last_s1 <= last_next;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	a_pop_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> $past(accept && item.func))
		else $error("pop state without line request");
	a_line_bytes_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind == KIND_LINE) && !result.last |=>
		strobe && (result.kind == KIND_LINE))
		else $error("gap inside line transaction");
	a_single_results_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.kind != KIND_LINE) |-> result.last)
		else $error("single result without last");
	a_overflow_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.end_overflow |->
		(result.kind == KIND_NONE) || (result.kind == KIND_ECHO))
		else $error("overflow flag on line result");

endmodule

### sim/tlrb_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the line receive buffer testbench: a shadow of the text ring,
// the end-position queue and the registers, and the queue of expected results.
// Depends on tlrb_pkg.
package tlrb_sb_pkg;
	import tlrb_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int END_DEPTH  = 16;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int END_AW     = $clog2(END_DEPTH);

	// Input transaction codes
	localparam logic FUNC_RX       = 1'b0;
	localparam logic FUNC_LINE_REQ = 1'b1;

	class line_buffer_sb;
		logic [7:0]         ring [RING_DEPTH];
		logic [RING_AW-1:0] wr_ptr;
		logic [RING_AW-1:0] rd_ptr;
		logic [RING_AW-1:0] end_fifo [END_DEPTH];
		logic [END_AW-1:0]  end_head;
		logic [END_AW-1:0]  end_tail;
		logic [END_AW:0]    end_count;
		logic [7:0]         term_char;
		logic [7:0]         print_min;
		logic               echo_on;
		tlrb_out_t          expected_q [$];
		int unsigned        n_err;

		function new();
			wr_ptr    = '0;
			rd_ptr    = '0;
			end_head  = '0;
			end_tail  = '0;
			end_count = '0;
			term_char = 8'd10;
			print_min = 8'd32;
			echo_on   = 1'b0;
			n_err     = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TERMINATOR: term_char = data;
				CFG_PRINT_MIN:  print_min = data;
				CFG_ECHO_MODE:  echo_on   = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void queue_result(logic [1:0] kind, logic [7:0] b, logic last, logic ovf);
			tlrb_out_t r;
			r.kind         = kind;
			r.out_byte     = b;
			r.last         = last;
			r.end_overflow = ovf;
			expected_q.push_back(r);
		endfunction

		// Predict the results of one accepted input transaction
		function void note_item(tlrb_in_t it);
			logic               dropped;
			logic [RING_AW-1:0] stop_pos;
			logic [RING_AW-1:0] pos;
			logic [RING_AW-1:0] line_len;
			dropped = 1'b0;
			if (it.func == FUNC_RX) begin
				// terminator test wins over the printable test
				if (it.rx_byte == term_char) begin
					if (end_count < END_DEPTH) begin
						end_fifo[end_tail] = wr_ptr;
						end_tail  = end_tail + 1'b1;
						end_count = end_count + 1'b1;
					end else begin
						dropped = 1'b1;
					end
				end else if (it.rx_byte >= print_min) begin
					ring[wr_ptr] = it.rx_byte;
					wr_ptr = wr_ptr + 1'b1;
				end
				if (echo_on)
					queue_result(KIND_ECHO, it.rx_byte, 1'b1, dropped);
				else if (dropped)
					queue_result(KIND_NONE, 8'd0, 1'b1, 1'b1);
			end else if (end_count == 0) begin
				queue_result(KIND_NONE, 8'd0, 1'b1, 1'b0);
			end else begin
				stop_pos  = end_fifo[end_head];
				end_head  = end_head + 1'b1;
				end_count = end_count - 1'b1;
				line_len  = stop_pos - rd_ptr;  // wraps modulo ring depth
				pos       = rd_ptr;
				rd_ptr    = stop_pos;
				if (line_len == 0) begin
					queue_result(KIND_EMPTY, 8'd0, 1'b1, 1'b0);
				end else begin
					for (int i = 0; i < line_len; i++) begin
						queue_result(KIND_LINE, ring[pos], (i == line_len - 1), 1'b0);
						pos = pos + 1'b1;
					end
				end
			end
		endfunction

		// Compare one result transaction with the oldest expectation
		function void check_result(tlrb_out_t got);
			tlrb_out_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: kind %0d out_byte %02h last %0b end_overflow %0b",
					got.kind, got.out_byte, got.last, got.end_overflow);
				n_err++;
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				n_err++;
			end
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
				n_err++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				n_err++;
			end
			if (got.end_overflow !== want.end_overflow) begin
				$error("end_overflow: expected %0b, actual %0b",
					want.end_overflow, got.end_overflow);
				n_err++;
			end
		endfunction

		function void check_drained();
			if (expected_q.size() != 0) begin
				$error("%0d expected results never arrived", expected_q.size());
				n_err++;
			end
		endfunction
	endclass

endpackage

### sim/tb_terminated_line_receive_buffer_core.sv
`timescale 1ns / 100ps
// Testbench for terminated_line_receive_buffer_core: directed and random text,
// terminators and line requests under several register settings.
// Depends on tlrb_pkg, tlrb_sb_pkg and the block's RTL.
module tb_terminated_line_receive_buffer_core;
	import tlrb_pkg::*;
	import tlrb_sb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_TAIL   = 4;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 45;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	tlrb_in_t              item;
	logic                  strobe;
	tlrb_out_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	line_buffer_sb sb = new();
	int unsigned   n_sent   = 0;
	int unsigned   n_cycles = 0;
	int            max_gap  = 5;

	terminated_line_receive_buffer_core #(
		.RING_DEPTH(RING_DEPTH),
		.END_DEPTH (END_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.strobe   (strobe),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Timeout guard
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Monitor: check result transactions, note accepted input transactions
	always @(posedge clk) begin
		if (strobe === 1'b1)
			sb.check_result(result);
		if (start === 1'b1 && busy === 1'b0)
			sb.note_item(item);
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// A byte that goes into the ring under the current settings
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(sb.print_min, 255));
		if (b == sb.term_char)
			b = (b == 8'hFF) ? sb.print_min : b + 8'd1;
		return b;
	endfunction

	task automatic send_item(input logic f, input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		item.func    <= f;
		item.rx_byte <= b;
		do @(posedge clk); while (busy !== 1'b0);
		n_sent++;
	endtask

	task automatic send_line(input int len);
		repeat (len) send_item(FUNC_RX, text_byte());
		send_item(FUNC_RX, sb.term_char);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || busy !== 1'b0);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// Registers are only written with the block idle
	task automatic write_config(input logic [7:0] term, input logic [7:0] pmin,
		input logic echo);
		logic [7:0] echo_word;
		echo_word = {7'($urandom_range(0, 127)), echo};
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TERMINATOR;
		cfg_data  <= term;
		@(posedge clk);
		sb.set_register(CFG_TERMINATOR, term);
		cfg_index <= CFG_PRINT_MIN;
		cfg_data  <= pmin;
		@(posedge clk);
		sb.set_register(CFG_PRINT_MIN, pmin);
		cfg_index <= CFG_ECHO_MODE;
		cfg_data  <= echo_word;
		@(posedge clk);
		sb.set_register(CFG_ECHO_MODE, echo_word);
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		// reset settings: no line, dropped control bytes, a line, an empty line
		send_item(FUNC_LINE_REQ, rand_byte());
		send_item(FUNC_RX, 8'h00);
		send_item(FUNC_RX, 8'h1F);
		send_item(FUNC_RX, 8'h20);
		send_item(FUNC_RX, 8'hFF);
		send_item(FUNC_RX, 8'h41);
		send_item(FUNC_RX, 8'h0A);
		send_item(FUNC_RX, 8'h0A);
		send_item(FUNC_LINE_REQ, 8'h00);
		send_item(FUNC_LINE_REQ, 8'hFF);
		send_item(FUNC_LINE_REQ, rand_byte());
		// printable terminator, everything stored, echo on
		write_config(8'h41, 8'h00, 1'b1);
		send_item(FUNC_RX, 8'h00);
		send_item(FUNC_RX, 8'h41);
		send_item(FUNC_RX, 8'hFF);
		send_item(FUNC_LINE_REQ, rand_byte());
		send_item(FUNC_LINE_REQ, rand_byte());
		// top of the byte range for both registers
		write_config(8'hFF, 8'hFF, 1'b0);
		send_item(FUNC_RX, 8'hFE);
		send_item(FUNC_RX, 8'hFF);
		send_item(FUNC_LINE_REQ, rand_byte());
	endtask

	// One random chunk of traffic, mostly whole lines
	task automatic run_pattern();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(30, 63);
			else
				len = $urandom_range(0, 8);
			send_line(len);
			if ($urandom_range(0, 1) == 0)
				send_item(FUNC_LINE_REQ, rand_byte());
		end else if (pick < 65) begin
			send_item(FUNC_LINE_REQ, rand_byte());
		end else if (pick < 77) begin
			send_item(FUNC_RX, rand_byte());
		end else if (pick < 85) begin
			// 12 to 20 terminators, at times enough to fill the end queue and overflow it
			repeat ($urandom_range(12, 20)) send_item(FUNC_RX, sb.term_char);
		end else begin
			repeat ($urandom_range(2, 6)) send_item(FUNC_LINE_REQ, rand_byte());
		end
	endtask

	task automatic run_random();
		int unsigned phase_end;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: write_config(8'd10, 8'd32, 1'b0);
				1: write_config(8'h00, 8'h00, 1'b1);
				2: write_config(8'hFF, 8'h80, 1'b0);
				4: write_config(8'd13, 8'h7F, 1'b1);
				default: write_config(rand_byte(), 8'($urandom_range(0, 96)),
					1'($urandom_range(0, 1)));
			endcase
			max_gap   = ($urandom_range(0, 2) == 0) ? 0 : 5;
			phase_end = n_sent + PHASE_ITEMS;
			while (n_sent < phase_end)
				run_pattern();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_idle();
		sb.check_drained();
		if (sb.n_err == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
src/tlrb_pkg.sv
src/tlrb_ring.sv
src/tlrb_endq.sv
src/terminated_line_receive_buffer_core.sv
sim/tlrb_sb_pkg.sv
sim/tb_terminated_line_receive_buffer_core.sv
